// ===== rtl/wfs_pkg.sv =====
// ============================================================================
// wfs_pkg : shared types and constants
// Types and fixed constants for the winnowing fingerprint stream unit.
// ============================================================================
package wfs_pkg;

    // field widths
    localparam int CHAR_W       = 8;
    localparam int HASH_W       = 64;
    localparam int KEPT_W       = 6;
    localparam int KGRAM_REG_W  = 6;
    localparam int WINDOW_REG_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_KGRAM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

    // register reset values
    localparam int KGRAM_RESET  = 10;
    localparam int WINDOW_RESET = 5;

    // hash base 31 is (1 << 5) - 1
    localparam int BASE_SHIFT = 5;

    // kept byte counter saturates here
    localparam logic [KEPT_W-1:0] KEPT_SAT = 6'd63;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified item travelling from front to back
    typedef struct packed {
        logic              kept;
        logic [CHAR_W-1:0] ch;
        logic              eot;
    } t_item;

    // result tag travelling alongside the window minimum
    typedef struct packed {
        logic vld;
        logic eot;
    } t_tag;

endpackage

// ===== rtl/wfs_if.sv =====
// ============================================================================
// wfs_if : channel interfaces
// Valid/ready channels for text bytes, fingerprints and register writes.
// ============================================================================

// text byte channel
interface wfs_in_if;
    logic                        valid;
    logic                        ready;
    logic [wfs_pkg::CHAR_W-1:0]  char_in;
    logic                        end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

// fingerprint channel
interface wfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [wfs_pkg::HASH_W-1:0]  fingerprint;
    logic                        text_end;

    modport source (output valid, output fingerprint, output text_end, input ready);
    modport sink   (input valid, input fingerprint, input text_end, output ready);
endinterface

// register write channel
interface wfs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wfs_pkg::CFG_IDX_W-1:0] index;
    logic [wfs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wfs_front.sv =====
// ============================================================================
// wfs_front : byte classifier
// Drops whitespace, lowercases letters and pushes kept bytes, and dropped bytes that end a text, into the queue.
// ============================================================================
module wfs_front (
    wfs_in_if.sink           i_in,
    input  logic             i_busy,
    input  logic             i_full,
    output logic             o_push,
    output wfs_pkg::t_item   o_item
);

    logic                        blank;
    logic [wfs_pkg::CHAR_W-1:0]  ch_low;

    // whitespace and case folding
    always_comb begin
        blank  = i_in.char_in inside {wfs_pkg::CH_SPACE, [wfs_pkg::CH_TAB:wfs_pkg::CH_CR]};
        ch_low = i_in.char_in;
        if (i_in.char_in inside {[wfs_pkg::CH_UPPER_A:wfs_pkg::CH_UPPER_Z]}) begin
            ch_low = i_in.char_in + wfs_pkg::CASE_OFFSET;
        end
    end

    // handshake: a dropped byte only travels on when it ends a text
    assign i_in.ready  = !i_busy && !i_full;
    assign o_push      = i_in.valid && i_in.ready && (!blank || i_in.end_of_text);
    assign o_item.kept = !blank;
    assign o_item.ch   = ch_low;
    assign o_item.eot  = i_in.end_of_text;

endmodule

// ===== rtl/wfs_fifo.sv =====
// ============================================================================
// wfs_fifo : front to back queue
// Short queue of classified items so that front and back stall separately.
// ============================================================================
module wfs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wfs_pkg::t_item  i_item,
    input  logic            i_pop,
    output wfs_pkg::t_item  o_item,
    output logic            o_empty,
    output logic            o_full
);

    localparam int DEPTH = wfs_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    wfs_pkg::t_item    r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CNTW-1:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_item  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

// ===== rtl/wfs_back.sv =====
// ============================================================================
// wfs_back : rolling hash engine
// Rolls the k-gram hash over kept bytes and shifts hashes into the window.
// ============================================================================
module wfs_back #(
    parameter int MAX_KGRAM  = 32,
    parameter int MAX_WINDOW = 16,
    parameter int KW         = 6,
    parameter int WW         = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [KW-1:0]               i_keff,
    input  logic [WW-1:0]               i_weff,
    input  logic [wfs_pkg::HASH_W-1:0]  i_pow31,
    input  logic                        i_valid,
    input  wfs_pkg::t_item              i_item,
    input  logic                        i_adv,
    output logic                        o_pop,
    output logic [wfs_pkg::HASH_W-1:0]  o_hashes [MAX_WINDOW],
    output wfs_pkg::t_tag               o_tag
);

    localparam int KIW = (MAX_KGRAM > 1) ? $clog2(MAX_KGRAM) : 1;
    localparam int CW  = (KW > wfs_pkg::KEPT_W) ? KW : wfs_pkg::KEPT_W;

    logic [wfs_pkg::CHAR_W-1:0]  r_chars [MAX_KGRAM];
    logic [wfs_pkg::HASH_W-1:0]  r_hashes [MAX_WINDOW];
    logic [wfs_pkg::HASH_W-1:0]  r_hash;
    logic [wfs_pkg::KEPT_W-1:0]  r_kept;
    logic [WW-1:0]               r_hcnt;
    wfs_pkg::t_tag               r_tag;

    logic [KW-1:0]               kidx;
    logic [wfs_pkg::CHAR_W-1:0]  old_ch;
    logic                        full;
    logic                        full_new;
    logic [wfs_pkg::KEPT_W-1:0]  n_kept;
    logic [WW-1:0]               n_hcnt;
    logic [wfs_pkg::HASH_W-1:0]  sub;
    logic [wfs_pkg::HASH_W-1:0]  n_hash;
    logic                        emit;
    logic                        take;

    assign o_pop = i_adv && i_valid;
    assign take  = o_pop && i_item.kept;

    // byte leaving the k-gram
    assign kidx   = i_keff - KW'(1);
    assign old_ch = r_chars[kidx[KIW-1:0]];

    // hash update: 31*h - old*31^k + c, modulo 2^64
    always_comb begin
        full     = (CW'(r_kept) >= CW'(i_keff));
        n_kept   = (r_kept == wfs_pkg::KEPT_SAT) ? r_kept : r_kept + wfs_pkg::KEPT_W'(1);
        full_new = (CW'(n_kept) >= CW'(i_keff));
        n_hcnt   = (r_hcnt == WW'(MAX_WINDOW)) ? r_hcnt : r_hcnt + WW'(1);
        emit     = full_new && (n_hcnt >= i_weff);
        sub      = full ? (wfs_pkg::HASH_W'(old_ch) * i_pow31) : '0;
        n_hash   = (r_hash << wfs_pkg::BASE_SHIFT) - r_hash - sub
                   + wfs_pkg::HASH_W'(i_item.ch);
    end

    // character and hash shift lines
    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = MAX_KGRAM - 1; i > 0; i--) begin
                r_chars[i] <= r_chars[i-1];
            end
            r_chars[0] <= i_item.ch;
            if (full_new) begin
                for (int j = MAX_WINDOW - 1; j > 0; j--) begin
                    r_hashes[j] <= r_hashes[j-1];
                end
                r_hashes[0] <= n_hash;
            end
        end
    end

    // hash, counters and result tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_kept <= '0;
            r_hcnt <= '0;
            r_tag  <= '0;
        end else begin
            if (take) begin
                r_hash <= n_hash;
                r_kept <= n_kept;
                if (full_new) begin
                    r_hcnt <= n_hcnt;
                end
            end
            if (o_pop && i_item.eot) begin
                r_hash <= '0;
                r_kept <= '0;
                r_hcnt <= '0;
            end
            if (i_adv) begin
                r_tag.vld <= take && emit;
                r_tag.eot <= i_item.eot;
            end
        end
    end

    assign o_hashes = r_hashes;
    assign o_tag    = r_tag;

endmodule

// ===== rtl/wfs_min_tree.sv =====
// ============================================================================
// wfs_min_tree : window minimum
// Registered compare tree over the hash window, one level per stage; the
// root register is the output register.
// ============================================================================
module wfs_min_tree #(
    parameter int MAX_WINDOW = 16,
    parameter int WW         = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wfs_pkg::HASH_W-1:0]  i_hashes [MAX_WINDOW],
    input  logic [WW-1:0]               i_weff,
    input  wfs_pkg::t_tag               i_tag,
    output logic                        o_adv,
    wfs_out_if.source                   o_out
);

    localparam int LV = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0;
    localparam int NW = 1 << LV;

    logic [wfs_pkg::HASH_W-1:0] leaf [NW];

    // stages move together whenever the output slot is free or taken
    assign o_adv = !o_out.valid || o_out.ready;

    // entries outside the window read as the largest value
    for (genvar i = 0; i < NW; i++) begin : g_leaf
        if (i < MAX_WINDOW) begin : g_used
            assign leaf[i] = (WW'(i) < i_weff) ? i_hashes[i] : '1;
        end else begin : g_pad
            assign leaf[i] = '1;
        end
    end

    if (LV == 0) begin : g_flat
        // single entry window
        assign o_out.valid       = i_tag.vld;
        assign o_out.fingerprint = leaf[0];
        assign o_out.text_end    = i_tag.eot;
    end else begin : g_tree
        logic [wfs_pkg::HASH_W-1:0] r_node [NW-1];
        logic [wfs_pkg::HASH_W-1:0] n_node [NW-1];
        wfs_pkg::t_tag              r_tags [1:LV];

        // node j takes the smaller of its two children
        for (genvar j = 0; j < NW - 1; j++) begin : g_node
            if (2 * j + 1 < NW - 1) begin : g_inner
                assign n_node[j] = (r_node[2*j+2] < r_node[2*j+1]) ?
                                   r_node[2*j+2] : r_node[2*j+1];
            end else begin : g_bottom
                assign n_node[j] = (leaf[2*j+2-(NW-1)] < leaf[2*j+1-(NW-1)]) ?
                                   leaf[2*j+2-(NW-1)] : leaf[2*j+1-(NW-1)];
            end
        end

        // compare levels
        always_ff @(posedge i_clk) begin
            if (o_adv) begin
                r_node <= n_node;
            end
        end

        // tags follow the levels
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int l = 1; l <= LV; l++) begin
                    r_tags[l] <= '0;
                end
            end else if (o_adv) begin
                r_tags[1] <= i_tag;
                for (int l = 2; l <= LV; l++) begin
                    r_tags[l] <= r_tags[l-1];
                end
            end
        end

        assign o_out.valid       = r_tags[LV].vld;
        assign o_out.fingerprint = r_node[0];
        assign o_out.text_end    = r_tags[LV].eot;
    end

endmodule

// ===== rtl/winnowing_fingerprint_stream_unit.sv =====
// ============================================================================
// winnowing_fingerprint_stream_unit : winnowing fingerprint generator
// Rolling hash over k-grams of kept text bytes and window minimum output.
// ============================================================================
// Usage
//   i_in   : one text byte per transaction with an end_of_text flag. Whitespace
//            is dropped, A-Z is lowercased.
//   o_out  : one fingerprint per kept byte once kgram_len + window_len - 1
//            bytes of the current text are kept; text_end marks one from the ending byte.
//   i_cfg  : register writes, index 0 kgram_len, index 1 window_len; always
//            ready. Write only while no text byte is in flight.
//   Throughput: one byte per cycle while neither the 31^k sequencer nor
//   the receiver holds the flow. A byte passes the queue and the hash engine
//   register, then one register per level of the window minimum tree.
//   After reset and after every kgram_len write, 31^k is rebuilt by a
//   shift-and-subtract sequencer while i_in is held not ready.
//   When the receiver stalls, the compare tree and hash engine hold, the
//   two-entry queue fills and i_in.ready then drops; nothing is lost.
// ============================================================================
module winnowing_fingerprint_stream_unit #(
    parameter int MAX_KGRAM  = 32,
    parameter int MAX_WINDOW = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfs_cfg_if.sink     i_cfg,
    wfs_in_if.sink      i_in,
    wfs_out_if.source   o_out
);

    localparam int KW    = $clog2(MAX_KGRAM + 1);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int KCW   = (KW > wfs_pkg::KGRAM_REG_W) ? KW : wfs_pkg::KGRAM_REG_W;
    localparam int WCW   = (WW > wfs_pkg::WINDOW_REG_W) ? WW : wfs_pkg::WINDOW_REG_W;
    localparam int K_RST = (wfs_pkg::KGRAM_RESET > MAX_KGRAM) ? MAX_KGRAM
                                                              : wfs_pkg::KGRAM_RESET;
    localparam int W_RST = (wfs_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                : wfs_pkg::WINDOW_RESET;

    logic [KW-1:0]               r_keff;
    logic [WW-1:0]               r_weff;
    logic [KW-1:0]               r_pcnt;
    logic [wfs_pkg::HASH_W-1:0]  r_pow;

    logic                        cfg_wr;
    logic [KCW-1:0]              kraw;
    logic [WCW-1:0]              wraw;
    logic [KW-1:0]               n_keff;
    logic [WW-1:0]               n_weff;
    logic                        busy;

    logic                        push;
    logic                        pop;
    logic                        q_empty;
    logic                        q_full;
    logic                        adv;
    wfs_pkg::t_item              f_item;
    wfs_pkg::t_item              q_item;
    logic [wfs_pkg::HASH_W-1:0]  hashes [MAX_WINDOW];
    wfs_pkg::t_tag               tag;

    // register writes with range clamping
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign kraw        = KCW'(i_cfg.data[wfs_pkg::KGRAM_REG_W-1:0]);
    assign wraw        = WCW'(i_cfg.data[wfs_pkg::WINDOW_REG_W-1:0]);
    assign n_keff      = (kraw == '0) ? KW'(1) :
                         (kraw > KCW'(MAX_KGRAM)) ? KW'(MAX_KGRAM) : kraw[KW-1:0];
    assign n_weff      = (wraw == '0) ? WW'(1) :
                         (wraw > WCW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : wraw[WW-1:0];
    assign busy        = (r_pcnt != '0);

    // settings and 31^k sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keff <= KW'(K_RST);
            r_weff <= WW'(W_RST);
            r_pcnt <= KW'(K_RST);
            r_pow  <= wfs_pkg::HASH_W'(1);
        end else begin
            if (cfg_wr && i_cfg.index == wfs_pkg::REG_KGRAM) begin
                r_keff <= n_keff;
                r_pcnt <= n_keff;
                r_pow  <= wfs_pkg::HASH_W'(1);
            end else if (busy) begin
                r_pcnt <= r_pcnt - KW'(1);
                r_pow  <= (r_pow << wfs_pkg::BASE_SHIFT) - r_pow;
            end
            if (cfg_wr && i_cfg.index == wfs_pkg::REG_WINDOW) begin
                r_weff <= n_weff;
            end
        end
    end

    // front: classify bytes
    wfs_front u_front (
        .i_in   (i_in),
        .i_busy (busy),
        .i_full (q_full),
        .o_push (push),
        .o_item (f_item)
    );

    // queue between front and back
    wfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: rolling hash and window shift
    wfs_back #(
        .MAX_KGRAM  (MAX_KGRAM),
        .MAX_WINDOW (MAX_WINDOW),
        .KW         (KW),
        .WW         (WW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_keff   (r_keff),
        .i_weff   (r_weff),
        .i_pow31  (r_pow),
        .i_valid  (!q_empty),
        .i_item   (q_item),
        .i_adv    (adv),
        .o_pop    (pop),
        .o_hashes (hashes),
        .o_tag    (tag)
    );

    // window minimum and output register
    wfs_min_tree #(
        .MAX_WINDOW (MAX_WINDOW),
        .WW         (WW)
    ) u_min_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hashes (hashes),
        .i_weff   (r_weff),
        .i_tag    (tag),
        .o_adv    (adv),
        .o_out    (o_out)
    );

`ifndef SYNTH
    // a k-gram length write always starts the power sequence
    a_kgram_starts_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_cfg.index == wfs_pkg::REG_KGRAM) |=> (r_pcnt != '0))
        else $error("power sequence did not start after kgram write");

    // the sequence counts down by one per cycle
    a_seq_counts_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !cfg_wr) |=> (r_pcnt == $past(r_pcnt) - KW'(1)))
        else $error("power sequence counter skipped");

    // no text byte is taken while 31^k is being rebuilt
    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cfg_wr && i_cfg.index == wfs_pkg::REG_KGRAM) |-> !(i_in.valid && i_in.ready))
        else $error("byte accepted during power sequence");
`endif

endmodule

// ===== verif/winnowing_fingerprint_stream_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// winnowing_fingerprint_stream_unit_tb : self-checking testbench
// Feeds text bytes through the valid/ready channels and predicts every
// fingerprint with an in-bench rolling hash and window minimum. Covers
// character classes, short texts, register extremes, mid-text length changes,
// long texts, full-rate streams, receiver hold-off and sender pauses.
// ============================================================================
module winnowing_fingerprint_stream_unit_tb;

    localparam int          MAX_KGRAM     = 32;
    localparam int          MAX_WINDOW    = 16;
    localparam logic [63:0] HASH_BASE     = 64'd31;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          STALL_CYCLES  = 300;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASES        = 14;
    localparam int          PHASE_ITEMS   = 60;
    localparam int          REPORT_LIMIT  = 10;

    // register settings swept by the random phases, extremes and out-of-range
    localparam logic [wfs_pkg::CFG_DATA_W-1:0] KGRAM_PICKS [12] =
        '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd10, 6'd2, 6'd5, 6'd32, 6'd1, 6'd17, 6'd7};
    localparam logic [wfs_pkg::CFG_DATA_W-1:0] WINDOW_PICKS [12] =
        '{6'd1, 6'd16, 6'd0, 6'd31, 6'd17, 6'd5, 6'd3, 6'd16, 6'd1, 6'd16, 6'h21, 6'h3F};

    typedef struct packed {
        logic [wfs_pkg::HASH_W-1:0] fingerprint;
        logic                       text_end;
    } t_fp_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wfs_cfg_if cfg_bus ();
    wfs_in_if  in_bus ();
    wfs_out_if out_bus ();

    winnowing_fingerprint_stream_unit #(
        .MAX_KGRAM  (MAX_KGRAM),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // clock, 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predicted block state
    logic [wfs_pkg::CHAR_W-1:0]       kept_chars [MAX_KGRAM];
    logic [wfs_pkg::HASH_W-1:0]       window_hashes [MAX_WINDOW];
    logic [wfs_pkg::HASH_W-1:0]       roll_hash;
    logic [wfs_pkg::HASH_W-1:0]       top_pow;
    int unsigned                      kept_n;
    int unsigned                      hash_n;
    logic [wfs_pkg::KGRAM_REG_W-1:0]  kgram_reg;
    logic [wfs_pkg::WINDOW_REG_W-1:0] window_reg;

    t_fp_result fingerprints_due [$];

    // run bookkeeping
    bit          idle_on      = 1'b1;
    bit          stall_req    = 1'b0;
    bit          stall_active = 1'b0;
    int unsigned errors       = 0;
    int unsigned bytes_sent   = 0;
    int unsigned texts_closed = 0;
    int unsigned fps_checked  = 0;
    int unsigned reg_writes   = 0;

    // append a predicted fingerprint at the tail of the list
    function automatic void expect_fingerprint(input logic [wfs_pkg::HASH_W-1:0] fp,
                                               input logic te);
        t_fp_result r;
        r.fingerprint = fp;
        r.text_end    = te;
        fingerprints_due.insert(fingerprints_due.size(), r);
    endfunction

    // take the oldest predicted fingerprint off the list
    function automatic t_fp_result oldest_expected();
        t_fp_result r;
        r = fingerprints_due[0];
        fingerprints_due.delete(0);
        return r;
    endfunction

    function automatic int unsigned kgram_eff();
        if (kgram_reg == 0) return 1;
        if (kgram_reg > MAX_KGRAM) return MAX_KGRAM;
        return kgram_reg;
    endfunction

    function automatic int unsigned window_eff();
        if (window_reg == 0) return 1;
        if (window_reg > MAX_WINDOW) return MAX_WINDOW;
        return window_reg;
    endfunction

    // weight of the byte leaving the k-gram, 31^(k-1) mod 2^64
    function automatic void rebuild_power();
        int unsigned i;
        top_pow = 64'd1;
        for (i = 1; i < kgram_eff(); i++) top_pow = top_pow * HASH_BASE;
    endfunction

    function automatic void clear_text();
        kept_n    = 0;
        hash_n    = 0;
        roll_hash = '0;
    endfunction

    // roll one accepted byte through hash and window, queue any fingerprint
    function automatic void winnow_byte(input logic [wfs_pkg::CHAR_W-1:0] c, input logic eot);
        logic [wfs_pkg::CHAR_W-1:0] ch;
        logic [wfs_pkg::HASH_W-1:0] low;
        int unsigned                k;
        int unsigned                w;
        int                         i;
        bit                         blank;
        ch    = c;
        blank = (ch == wfs_pkg::CH_SPACE) || (ch >= wfs_pkg::CH_TAB && ch <= wfs_pkg::CH_CR);
        if (!blank) begin
            k = kgram_eff();
            w = window_eff();
            if (ch >= wfs_pkg::CH_UPPER_A && ch <= wfs_pkg::CH_UPPER_Z)
                ch = ch + wfs_pkg::CASE_OFFSET;
            if (kept_n >= k)
                roll_hash = (roll_hash - 64'(kept_chars[k-1]) * top_pow) * HASH_BASE + 64'(ch);
            else
                roll_hash = roll_hash * HASH_BASE + 64'(ch);
            for (i = MAX_KGRAM - 1; i > 0; i--) kept_chars[i] = kept_chars[i-1];
            kept_chars[0] = ch;
            if (kept_n < wfs_pkg::KEPT_SAT) kept_n++;
            if (kept_n >= k) begin
                for (i = MAX_WINDOW - 1; i > 0; i--) window_hashes[i] = window_hashes[i-1];
                window_hashes[0] = roll_hash;
                if (hash_n < MAX_WINDOW) hash_n++;
                if (hash_n >= w) begin
                    low = window_hashes[0];
                    for (i = 1; i < w; i++)
                        if (window_hashes[i] < low) low = window_hashes[i];
                    expect_fingerprint(low, eot);
                end
            end
        end
        if (eot) clear_text();
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function automatic bit take_gap();
        return idle_on && ($urandom_range(0, 99) < 31);
    endfunction

    // mostly letters of both cases, some whitespace, some arbitrary bytes
    function automatic logic [wfs_pkg::CHAR_W-1:0] pick_text_char();
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return wfs_pkg::CH_UPPER_A + wfs_pkg::CASE_OFFSET + 8'($urandom_range(0, 25));
        if (roll < 72) return wfs_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
        if (roll < 84) begin
            pick = $urandom_range(0, 5);
            return (pick == 5) ? wfs_pkg::CH_SPACE : wfs_pkg::CH_TAB + 8'(pick);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // -------------------------------------------------------------------------
    // channel tasks
    // -------------------------------------------------------------------------

    // offer one byte, leave valid high after the transaction
    task automatic send_byte(input logic [wfs_pkg::CHAR_W-1:0] c, input logic eot);
        @(negedge clk);
        while (take_gap()) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.char_in     <= c;
        in_bus.end_of_text <= eot;
        do @(posedge clk); while (!in_bus.ready);
        winnow_byte(c, eot);
        bytes_sent++;
        if (eot) texts_closed++;
    endtask

    task automatic send_text(input int unsigned len, input bit close);
        int unsigned i;
        for (i = 0; i < len; i++) send_byte(pick_text_char(), close && (i == len - 1));
    endtask

    // stop offering, wait for every fingerprint and let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (stall_req || stall_active || fingerprints_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wfs_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == wfs_pkg::REG_KGRAM) begin
            kgram_reg = val[wfs_pkg::KGRAM_REG_W-1:0];
            rebuild_power();
        end else begin
            window_reg = val[wfs_pkg::WINDOW_REG_W-1:0];
        end
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // -------------------------------------------------------------------------
    // receiver, hold-off, checker and watchdog
    // -------------------------------------------------------------------------

    // fingerprint ready with random gaps
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_bus.ready <= !(stall_active || take_gap());
        end
    end

    // long receiver hold-off on request
    always begin
        @(posedge clk);
        if (stall_req) begin
            stall_active = 1'b1;
            repeat (STALL_CYCLES) @(posedge clk);
            stall_active = 1'b0;
            stall_req    = 1'b0;
        end
    end

    // compare each fingerprint transaction with the oldest prediction
    always @(posedge clk) begin
        t_fp_result due;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (fingerprints_due.size() == 0) begin
                note_failure($sformatf("unexpected fingerprint %h text_end %b",
                                       out_bus.fingerprint, out_bus.text_end));
            end else begin
                due = oldest_expected();
                if (out_bus.fingerprint !== due.fingerprint)
                    note_failure($sformatf("fingerprint expected %h actual %h",
                                           due.fingerprint, out_bus.fingerprint));
                if (out_bus.text_end !== due.text_end)
                    note_failure($sformatf("text_end expected %b actual %b",
                                           due.text_end, out_bus.text_end));
                fps_checked++;
            end
        end
    end

    // give up after a long run of cycles with no transaction anywhere
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // every byte class at k = 1, w = 1: blanks, case edges, byte extremes,
    // a kept final byte and a dropped final byte
    task automatic test_char_classes();
        logic [wfs_pkg::CHAR_W-1:0] bytes [21];
        int                         i;
        bytes = '{8'd0, 8'd255, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd31,
                  8'd32, 8'd33, 8'd64, 8'd65, 8'd90, 8'd122, 8'd91, 8'd96, 8'd97,
                  8'd123, 8'd32};
        settle();
        write_reg(wfs_pkg::REG_KGRAM, 6'd1);
        write_reg(wfs_pkg::REG_WINDOW, 6'd1);
        for (i = 0; i < 21; i++) send_byte(bytes[i], (i == 15) || (i == 20));
    endtask

    // too few kept bytes for a fingerprint, then exactly enough
    task automatic test_short_text();
        settle();
        write_reg(wfs_pkg::REG_KGRAM, 6'd2);
        write_reg(wfs_pkg::REG_WINDOW, 6'd2);
        send_byte(8'd97, 1'b0);
        send_byte(8'd66, 1'b1);
        send_byte(8'd97, 1'b0);
        send_byte(8'd66, 1'b0);
        send_byte(8'd99, 1'b1);
    endtask

    // register sweep with random texts; some phases end mid-text so the next
    // setting changes the length part way through
    task automatic test_random_texts();
        logic [wfs_pkg::CFG_DATA_W-1:0] kval;
        logic [wfs_pkg::CFG_DATA_W-1:0] wval;
        int unsigned                    ph;
        int unsigned                    sent;
        int unsigned                    len;
        bit                             last;
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            kval = (ph < 12) ? KGRAM_PICKS[ph] :
                               wfs_pkg::CFG_DATA_W'($urandom_range(0, 63));
            wval = (ph < 12) ? WINDOW_PICKS[ph] :
                               wfs_pkg::CFG_DATA_W'($urandom_range(0, 63));
            if (ph % 5 != 3) write_reg(wfs_pkg::REG_KGRAM, kval);
            if (ph % 5 != 4) write_reg(wfs_pkg::REG_WINDOW, wval);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (ph % 4 == 2) begin
                    // noise: arbitrary bytes and scattered text ends
                    send_byte(wfs_pkg::CHAR_W'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
                    sent++;
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(70, 100);
                    else
                        len = $urandom_range(1, kgram_eff() + window_eff() + 8);
                    last = (sent + len >= PHASE_ITEMS);
                    send_text(len, !(last && $urandom_range(0, 1)));
                    sent += len;
                end
            end
        end
    endtask

    // both sides at full rate
    task automatic test_full_rate();
        int unsigned sent;
        int unsigned len;
        settle();
        write_reg(wfs_pkg::REG_KGRAM, 6'd6);
        write_reg(wfs_pkg::REG_WINDOW, 6'd4);
        idle_on = 1'b0;
        sent = 0;
        while (sent < 200) begin
            len = $urandom_range(5, 40);
            send_text(len, 1'b1);
            sent += len;
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, block must stall
    task automatic test_backpressure();
        settle();
        write_reg(wfs_pkg::REG_KGRAM, 6'd4);
        write_reg(wfs_pkg::REG_WINDOW, 6'd3);
        idle_on   = 1'b0;
        stall_req = 1'b1;
        send_text(90, 1'b1);
        idle_on   = 1'b1;
    endtask

    // sender pauses mid-text until every fingerprint is out, then goes on
    task automatic test_pause_mid_text();
        settle();
        send_text(20, 1'b0);
        settle();
        send_text(20, 1'b1);
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial begin
        in_bus.valid       = 1'b0;
        in_bus.char_in     = '0;
        in_bus.end_of_text = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = wfs_pkg::REG_KGRAM;
        cfg_bus.data       = '0;
        kgram_reg          = wfs_pkg::KGRAM_REG_W'(wfs_pkg::KGRAM_RESET);
        window_reg         = wfs_pkg::WINDOW_REG_W'(wfs_pkg::WINDOW_RESET);
        clear_text();
        rebuild_power();

        // synchronous reset, then release
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_char_classes();
        test_short_text();
        test_random_texts();
        test_full_rate();
        test_backpressure();
        test_pause_mid_text();
        settle();

        $display("Run covered %0d bytes in %0d closed texts, %0d fingerprints checked,",
                 bytes_sent, texts_closed, fps_checked);
        $display("%0d register writes incl. out-of-range lengths, hold-off and pauses",
                 reg_writes);
        if (errors == 0 && fingerprints_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d errors, %0d fingerprints outstanding", errors,
                     fingerprints_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wfs_pkg.sv
rtl/wfs_if.sv
rtl/wfs_front.sv
rtl/wfs_fifo.sv
rtl/wfs_back.sv
rtl/wfs_min_tree.sv
rtl/winnowing_fingerprint_stream_unit.sv
verif/winnowing_fingerprint_stream_unit_tb.sv
